// ===== hw/rtl/running_moving_average_unit_assert.svh =====
// Assertion macros for the running moving average unit.
`ifndef RUNNING_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define RUNNING_MOVING_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked property that is switched off while reset is applied.
`define RMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that is also evaluated while reset is applied.
`define RMA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMA_ASSERT(label, clk, rst_n, prop, msg)
`define RMA_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/rma_pkg.sv =====
// Shared constants of the running moving average unit.
package rma_pkg;

  // Width of one ADC sample and of one average.
  localparam int SAMPLE_W = 12;

  // Largest value that a sample can take.
  localparam int SAMPLE_MAX = 4095;

  // Default window length.
  localparam int DEPTH_DEFAULT = 16;

endpackage

// ===== hw/rtl/rma_if.sv =====
// Valid/ready channel interfaces for samples in and averages out.
interface rma_sample_if;
  import rma_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rma_average_if;
  import rma_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ===== hw/rtl/running_moving_average_unit.sv =====
// Top level of the running moving average unit: sample ring, running sum and divider.
//
// Usage
//   Samples enter on in_chan, one 12-bit ADC reading per item, accepted when
//   valid and ready are both high. For every sample one item leaves on
//   out_chan: the truncated mean of the samples now held in the window of
//   DEPTH entries. While the window fills, the mean is taken over the samples
//   received so far; the first average equals the first sample.
//   Steps: the ring is read and the running sum updated (ST_READ), the sum
//   goes through the restoring divider (ST_DIV), which produces one quotient
//   bit per cycle, SUM_W bits in all (16 at DEPTH 16), and the average is
//   loaded into the output register (ST_OUT). The block works on one item at
//   a time and takes the next sample only once that register has been loaded.
//   Stalls: if the receiver holds out_chan.ready low, a finished average
//   waits in the output register while the next sample is processed; the
//   next finished quotient then waits in ST_OUT until the register is free.
//   Reset: rst_n is synchronous and active low. It empties the window and
//   clears the running sum. No clearing pass is needed: the ring's read data
//   is only used once every entry has been written.
module running_moving_average_unit #(
  parameter int DEPTH = rma_pkg::DEPTH_DEFAULT
) (
  input logic            clk,
  input logic            rst_n,
  rma_sample_if.sink     in_chan,
  rma_average_if.source  out_chan
);
  import rma_pkg::*;

  // The running sum must hold DEPTH full-scale samples exactly.
  localparam int SUM_W  = $clog2(DEPTH * SAMPLE_MAX + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STEP_W = $clog2(SUM_W);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Control state.
  logic [1:0]          state_r,     state_nxt;
  logic [SUM_W-1:0]    sum_r,       sum_nxt;
  logic [CNT_W-1:0]    fill_r,      fill_nxt;
  logic [SLOT_W-1:0]   slot_r,      slot_nxt;
  logic [STEP_W-1:0]   step_r,      step_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [SAMPLE_W-1:0] sample_r,    sample_nxt;
  logic [SUM_W-1:0]    quo_r,       quo_nxt;
  logic [CNT_W-1:0]    rem_r,       rem_nxt;
  logic [SAMPLE_W-1:0] average_r,   average_nxt;

  // Sample ring, one write and one registered read per cycle.
  logic [SAMPLE_W-1:0] ring [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                ring_we;

  logic                in_fire;
  logic                out_free;
  logic                win_full;
  logic [CNT_W:0]      rem_shift;
  logic [CNT_W:0]      divisor_ext;
  logic                rem_ge;

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign in_fire          = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = average_r;
  assign out_free         = !out_valid_r || out_chan.ready;
  assign win_full         = (fill_r == CNT_W'(DEPTH));

  // One quotient bit per cycle. The partial remainder always stays below
  // the divisor, which is at most DEPTH, so CNT_W bits hold it.
  assign rem_shift   = {rem_r, quo_r[SUM_W-1]};
  assign divisor_ext = {1'b0, fill_r};
  assign rem_ge      = (rem_shift >= divisor_ext);

  // The ring is written in the cycle after the read of the same slot. As
  // only one item is in flight, the next read cannot reach that slot before
  // the write has landed, even when the window holds a single entry.
  assign ring_we = (state_r == ST_READ);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= sample_r;
    end
    rd_data_r <= ring[slot_r];
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    average_nxt   = average_r;

    // The receiver has taken the waiting average.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // The ring read of the current slot is issued in this cycle.
        if (in_fire) begin
          sample_nxt = in_chan.sample;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        // Once the window is full the oldest sample leaves the sum before
        // the new one enters; otherwise the window grows by one.
        if (win_full) begin
          sum_nxt = sum_r - SUM_W'(rd_data_r) + SUM_W'(sample_r);
        end else begin
          sum_nxt  = sum_r + SUM_W'(sample_r);
          fill_nxt = fill_r + CNT_W'(1);
        end
        if (slot_r == SLOT_W'(DEPTH - 1)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        quo_nxt   = sum_nxt;
        rem_nxt   = '0;
        step_nxt  = STEP_W'(SUM_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_nxt = CNT_W'(rem_shift - divisor_ext);
        end else begin
          rem_nxt = rem_shift[CNT_W-1:0];
        end
        quo_nxt = {quo_r[SUM_W-2:0], rem_ge};
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_OUT: begin
        // The mean never exceeds a full-scale sample, so the low bits of
        // the quotient are the whole result.
        if (out_free) begin
          average_nxt   = quo_r[SAMPLE_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    average_r <= average_nxt;
  end

`include "running_moving_average_unit_assert.svh"

  // An accepted sample always moves on to the ring read.
  `RMA_ASSERT(a_accept_reads, clk, rst_n, in_fire |=> (state_r == ST_READ), "accept lost")
  // The divider's partial remainder stays below the window count.
  `RMA_ASSERT(a_rem_bound, clk, rst_n, (state_r == ST_DIV) |-> (rem_r < fill_r), "remainder overflow")
  // The window count never exceeds the window length.
  `RMA_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CNT_W'(DEPTH), "fill count overflow")
  // A finished quotient fits in one sample width.
  `RMA_ASSERT(a_quo_fits, clk, rst_n, (state_r == ST_OUT) |-> ((quo_r >> SAMPLE_W) == '0), "average too wide")
  // Reset leaves no average on the output.
  `RMA_ASSERT_RST(a_reset_out, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
